>>> sv/crd_pkg.sv
`timescale 1ns / 1ps

package crd_pkg;

   // header is one flag byte then a 64-bit little-endian length
   localparam int HEADER_BYTES = 9;
   localparam int LAST_HEADER = HEADER_BYTES - 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   typedef logic [QUEUE_AW-1:0] qptr_type;
   typedef logic [QUEUE_AW:0] qcount_type;

   typedef enum logic [1:0] {
      CSR_BUFFER_COUNT   = 2'd0,
      CSR_BUFFER_LENGTH  = 2'd1,
      CSR_MAX_ERROR_CODE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_TEXT    = 2'd2,
      KIND_STATUS  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_AFTER_END = 3'd1,
      ST_TOO_LONG  = 3'd2,
      ST_BAD_FLAG  = 3'd3,
      ST_SERVER    = 3'd4,
      ST_NEED_MORE = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PH_HEADER      = 3'd0,
      PH_PAYLOAD     = 3'd1,
      PH_ERRTEXT     = 3'd2,
      PH_DONE_OK     = 3'd3,
      PH_DONE_SERVER = 3'd4,
      PH_FAIL_AFTER  = 3'd5,
      PH_FAIL_LONG   = 3'd6,
      PH_FAIL_FLAG   = 3'd7
   } phase_type;

   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_EOM  = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       link_ok;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic        buffer_index;
      logic [31:0] buffer_offset;
      logic [7:0]  data_out;
      status_type  status;
      logic [7:0]  error_code;
      logic        done_res;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  buffer_count;
      logic [31:0] buffer_length;
      logic [7:0]  max_error_code;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      buffer_count:   2'd1,
      buffer_length:  32'd1,
      max_error_code: 8'd255
   };

   // classified transaction handed from the parser to the output side
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      status_type status;
      logic [7:0] error_code;
      logic       done;
      logic       rearm;
   } entry_type;

   // payload bytes expected: buffer count clamped to 1..2 times buffer length
   function automatic logic [32:0] total_of(cfg_type cfg);
      logic two;
      two = cfg.buffer_count[1];
      return two ? {cfg.buffer_length, 1'b0} : {1'b0, cfg.buffer_length};
   endfunction

endpackage

>>> sv/chunked_response_deframer_core.sv
`timescale 1ns / 1ps

// Chunked response deframer. Takes a response stream one byte per
// transaction and returns exactly one result transaction for each one taken.
// The stream is a series of chunks with a 9-byte header (flag byte, then a
// 64-bit little-endian length); payload bytes come out tagged with their
// buffer index and offset, error text bytes are passed through, and status
// results report completion, bytes after the end, oversized chunks, bad
// flags and server errors. A transaction with mode set ends the message,
// gives the verdict and re-arms for the next response; a write to any of the
// three registers re-arms as well. Throughput is one transaction per clock
// while neither side stalls: the parser settles each byte in the cycle it is
// taken, and a four-entry queue plus the output register let the two sides
// stall independently. A result waits in the queue, then moves into the
// output register once the output is free. req_stall rises only while the
// queue is full. No clearing pass after reset.

module chunked_response_deframer_core (
   input  logic             clock,
   input  logic             reset,

   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  crd_pkg::req_type req_payload,

   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output crd_pkg::rsp_type rsp_payload,

   // register write port
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);

   crd_pkg::cfg_type   cfg_ff, cfg_in;
   logic               cfg_rearm;

   logic               req_accept;
   crd_pkg::entry_type front_entry;
   crd_pkg::entry_type queue_head;
   logic               queue_not_empty;
   logic               queue_full;
   logic               queue_pop;

   // register writes; an unused index leaves everything as it was
   always_comb begin
      cfg_in    = cfg_ff;
      cfg_rearm = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            crd_pkg::CSR_BUFFER_COUNT: begin
               cfg_in.buffer_count = csr_data[1:0];
               cfg_rearm           = 1'b1;
            end
            crd_pkg::CSR_BUFFER_LENGTH: begin
               cfg_in.buffer_length = csr_data;
               cfg_rearm            = 1'b1;
            end
            crd_pkg::CSR_MAX_ERROR_CODE: begin
               cfg_in.max_error_code = csr_data[7:0];
               cfg_rearm             = 1'b1;
            end
            default: cfg_rearm = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= crd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front side takes a transaction whenever the queue has room
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // parser: header assembly, chunk checks, phase tracking
   crd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .item      (req_payload),
      .cfg_in    (cfg_in),
      .cfg_rearm (cfg_rearm),
      .entry     (front_entry)
   );

   // classified transactions waiting for the output side
   crd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (front_entry),
      .pop        (queue_pop),
      .head       (queue_head),
      .not_empty  (queue_not_empty),
      .full       (queue_full)
   );

   // output side: buffer placement and the result register
   crd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (queue_head),
      .not_empty     (queue_not_empty),
      .pop           (queue_pop),
      .buffer_length (cfg_ff.buffer_length),
      .cfg_rearm     (cfg_rearm),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule

>>> sv/crd_front.sv
`timescale 1ns / 1ps

module crd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  crd_pkg::req_type   item,
   input  crd_pkg::cfg_type   cfg_in,
   input  logic               cfg_rearm,
   output crd_pkg::entry_type entry
);

   crd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic [32:0] len_ff, len_in;
   logic        hi_ff, hi_in;       // some length bit above bit 32 is set
   logic [32:0] chunk_ff, chunk_in;
   logic [32:0] total_ff, total_in;
   logic [7:0]  code_ff, code_in;

   logic        hi_fin;
   logic        rearm;
   logic [32:0] chunk_dec;
   logic [32:0] total_dec;

   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      len_in       = len_ff;
      hi_in        = hi_ff;
      chunk_in     = chunk_ff;
      total_in     = total_ff;
      code_in      = code_ff;
      rearm        = 1'b0;

      hi_fin    = hi_ff | (|item.data_byte);
      chunk_dec = chunk_ff - 33'd1;
      total_dec = total_ff - 33'd1;

      entry.kind       = crd_pkg::KIND_STATUS;
      entry.data       = 8'd0;
      entry.status     = crd_pkg::ST_OK;
      entry.error_code = 8'd0;
      entry.done       = 1'b1;
      entry.rearm      = 1'b0;

      if (item.mode == crd_pkg::MODE_EOM) begin
         entry.rearm = 1'b1;
         rearm       = 1'b1;
         case (phase_ff)
            crd_pkg::PH_DONE_SERVER: begin
               entry.status     = crd_pkg::ST_SERVER;
               entry.error_code = code_ff;
            end
            crd_pkg::PH_FAIL_AFTER:  entry.status = crd_pkg::ST_AFTER_END;
            crd_pkg::PH_FAIL_LONG:   entry.status = crd_pkg::ST_TOO_LONG;
            crd_pkg::PH_FAIL_FLAG:   entry.status = crd_pkg::ST_BAD_FLAG;
            crd_pkg::PH_DONE_OK: begin
               entry.status = item.link_ok ? crd_pkg::ST_OK : crd_pkg::ST_NEED_MORE;
            end
            default: entry.status = crd_pkg::ST_NEED_MORE;
         endcase
      end else begin
         case (phase_ff)
            crd_pkg::PH_HEADER: begin
               entry.kind   = crd_pkg::KIND_HEADER;
               entry.done   = 1'b0;
               hdr_count_in = hdr_count_ff + 4'd1;
               case (hdr_count_ff)
                  4'd0: begin
                     code_in = item.data_byte;
                     len_in  = 33'd0;
                     hi_in   = 1'b0;
                  end
                  4'd1: len_in[7:0]   = item.data_byte;
                  4'd2: len_in[15:8]  = item.data_byte;
                  4'd3: len_in[23:16] = item.data_byte;
                  4'd4: len_in[31:24] = item.data_byte;
                  4'd5: begin
                     len_in[32] = item.data_byte[0];
                     hi_in      = hi_ff | (|item.data_byte[7:1]);
                  end
                  default: hi_in = hi_fin;
               endcase
               if (hdr_count_ff == 4'(crd_pkg::LAST_HEADER)) begin
                  // header complete: check the chunk against what is left
                  hdr_count_in = 4'd0;
                  chunk_in     = len_ff;
                  if (code_ff == 8'd0) begin
                     if (hi_fin || (len_ff > total_ff)) begin
                        phase_in     = crd_pkg::PH_FAIL_LONG;
                        entry.status = crd_pkg::ST_TOO_LONG;
                        entry.done   = 1'b1;
                     end else if (len_ff == 33'd0) begin
                        if (total_ff == 33'd0) begin
                           phase_in   = crd_pkg::PH_DONE_OK;
                           entry.done = 1'b1;
                        end
                     end else begin
                        phase_in = crd_pkg::PH_PAYLOAD;
                     end
                  end else if (code_ff > cfg_in.max_error_code) begin
                     phase_in     = crd_pkg::PH_FAIL_FLAG;
                     entry.status = crd_pkg::ST_BAD_FLAG;
                     entry.done   = 1'b1;
                  end else if (hi_fin || len_ff[32]) begin
                     phase_in     = crd_pkg::PH_FAIL_LONG;
                     entry.status = crd_pkg::ST_TOO_LONG;
                     entry.done   = 1'b1;
                  end else if (len_ff == 33'd0) begin
                     // empty error chunk reports at once
                     phase_in         = crd_pkg::PH_DONE_SERVER;
                     entry.status     = crd_pkg::ST_SERVER;
                     entry.error_code = code_ff;
                     entry.done       = 1'b1;
                  end else begin
                     phase_in = crd_pkg::PH_ERRTEXT;
                  end
               end
            end
            crd_pkg::PH_PAYLOAD: begin
               entry.kind = crd_pkg::KIND_PAYLOAD;
               entry.data = item.data_byte;
               entry.done = 1'b0;
               chunk_in   = chunk_dec;
               total_in   = total_dec;
               if (total_dec == 33'd0) begin
                  phase_in   = crd_pkg::PH_DONE_OK;
                  entry.done = 1'b1;
               end else if (chunk_dec == 33'd0) begin
                  phase_in = crd_pkg::PH_HEADER;
               end
            end
            crd_pkg::PH_ERRTEXT: begin
               entry.kind = crd_pkg::KIND_TEXT;
               entry.data = item.data_byte;
               entry.done = 1'b0;
               chunk_in   = chunk_dec;
               if (chunk_dec == 33'd0) begin
                  phase_in         = crd_pkg::PH_DONE_SERVER;
                  entry.status     = crd_pkg::ST_SERVER;
                  entry.error_code = code_ff;
                  entry.done       = 1'b1;
               end
            end
            crd_pkg::PH_DONE_OK, crd_pkg::PH_DONE_SERVER: begin
               phase_in     = crd_pkg::PH_FAIL_AFTER;
               entry.status = crd_pkg::ST_AFTER_END;
            end
            crd_pkg::PH_FAIL_AFTER: entry.status = crd_pkg::ST_AFTER_END;
            crd_pkg::PH_FAIL_LONG:  entry.status = crd_pkg::ST_TOO_LONG;
            crd_pkg::PH_FAIL_FLAG:  entry.status = crd_pkg::ST_BAD_FLAG;
            default:                entry.status = crd_pkg::ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= crd_pkg::PH_HEADER;
         hdr_count_ff <= 4'd0;
         len_ff       <= 33'd0;
         hi_ff        <= 1'b0;
         chunk_ff     <= 33'd0;
         total_ff     <= crd_pkg::total_of(crd_pkg::CFG_RESET);
         code_ff      <= 8'd0;
      end else if (cfg_rearm || (accept && rearm)) begin
         phase_ff     <= crd_pkg::PH_HEADER;
         hdr_count_ff <= 4'd0;
         len_ff       <= 33'd0;
         hi_ff        <= 1'b0;
         chunk_ff     <= 33'd0;
         total_ff     <= crd_pkg::total_of(cfg_in);
         code_ff      <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         len_ff       <= len_in;
         hi_ff        <= hi_in;
         chunk_ff     <= chunk_in;
         total_ff     <= total_in;
         code_ff      <= code_in;
      end
   end

endmodule

>>> sv/crd_queue.sv
`timescale 1ns / 1ps

module crd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  crd_pkg::entry_type push_entry,
   input  logic               pop,
   output crd_pkg::entry_type head,
   output logic               not_empty,
   output logic               full
);

   crd_pkg::entry_type slots_ff [crd_pkg::QUEUE_DEPTH];
   crd_pkg::qptr_type   wr_ptr_ff, wr_ptr_in;
   crd_pkg::qptr_type   rd_ptr_ff, rd_ptr_in;
   crd_pkg::qcount_type count_ff, count_in;

   assign head      = slots_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == crd_pkg::qcount_type'(crd_pkg::QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? crd_pkg::qptr_type'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? crd_pkg::qptr_type'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = crd_pkg::qcount_type'(count_ff + 1'b1);
         2'b01:   count_in = crd_pkg::qcount_type'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/crd_back.sv
`timescale 1ns / 1ps

module crd_back (
   input  logic               clock,
   input  logic               reset,
   input  crd_pkg::entry_type head,
   input  logic               not_empty,
   output logic               pop,
   input  logic [31:0]        buffer_length,
   input  logic               cfg_rearm,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output crd_pkg::rsp_type   rsp_payload
);

   logic             rsp_valid_ff, rsp_valid_in;
   crd_pkg::rsp_type rsp_ff, rsp_in;
   logic             sel_ff, sel_in;
   logic [31:0]      offset_ff, offset_in;
   logic [32:0]      offset_next;

   assign pop         = not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      sel_in       = sel_ff;
      offset_in    = offset_ff;
      offset_next  = {1'b0, offset_ff} + 33'd1;

      if (pop) begin
         rsp_valid_in         = 1'b1;
         rsp_in.kind          = head.kind;
         rsp_in.buffer_index  = 1'b0;
         rsp_in.buffer_offset = 32'd0;
         rsp_in.data_out      = head.data;
         rsp_in.status        = head.status;
         rsp_in.error_code    = head.error_code;
         rsp_in.done_res      = head.done;
         if (head.kind == crd_pkg::KIND_PAYLOAD) begin
            // place the byte, then step to the next slot or buffer
            rsp_in.buffer_index  = sel_ff;
            rsp_in.buffer_offset = offset_ff;
            if (offset_next >= {1'b0, buffer_length}) begin
               offset_in = 32'd0;
               sel_in    = ~sel_ff;
            end else begin
               offset_in = offset_next[31:0];
            end
         end
         if (head.rearm) begin
            offset_in = 32'd0;
            sel_in    = 1'b0;
         end
      end
      if (cfg_rearm) begin
         offset_in = 32'd0;
         sel_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         offset_ff    <= 32'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
         offset_ff    <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   crd_pkg::req_type    req_payload = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   crd_pkg::rsp_type    rsp_payload;

   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   always #5 clock = ~clock;

   chunked_response_deframer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // shadow registers
   logic [1:0]  cfg_count = 2'd1;
   logic [31:0] cfg_length = 32'd1;
   logic [7:0]  cfg_max_code = 8'd255;

   // deframer state mirrored on the bench side
   crd_pkg::phase_type ph;
   logic [3:0]  hdr_cnt;
   logic [63:0] len_acc;
   logic [63:0] chunk_left;
   logic [63:0] total_left;
   logic        buf_sel;
   logic [31:0] byte_off;
   logic [7:0]  srv_code;

   crd_pkg::rsp_type deframed_q[$];

   int          errors = 0;
   int          sent_count = 0;
   int          results_seen = 0;
   int          csr_writes = 0;
   int          kind_hits[4] = '{0, 0, 0, 0};
   int          burst_left = 0;
   bit          gaps_off = 0;

   // receiver side pattern
   bit          hold_request = 0;
   int          hold_len = 0;
   int          hold_left = 0;
   int          recv_cycle = 0;
   int          stall_style = 1;

   crd_pkg::rsp_type want;
   crd_pkg::rsp_type got;

   // payload bytes one response carries: count clamped to 1..2
   function automatic logic [63:0] response_bytes();
      return {32'd0, cfg_length} << ((cfg_count >= 2'd2) ? 1 : 0);
   endfunction

   function automatic void rearm_model();
      ph = crd_pkg::PH_HEADER;
      hdr_cnt = '0;
      len_acc = '0;
      chunk_left = '0;
      total_left = response_bytes();
      buf_sel = 1'b0;
      byte_off = '0;
      srv_code = '0;
   endfunction

   function automatic crd_pkg::status_type latched_of(crd_pkg::phase_type p);
      case (p)
         crd_pkg::PH_FAIL_AFTER:  return crd_pkg::ST_AFTER_END;
         crd_pkg::PH_FAIL_LONG:   return crd_pkg::ST_TOO_LONG;
         crd_pkg::PH_FAIL_FLAG:   return crd_pkg::ST_BAD_FLAG;
         crd_pkg::PH_DONE_SERVER: return crd_pkg::ST_SERVER;
         default:                 return crd_pkg::ST_OK;
      endcase
   endfunction

   // one result per request, state advanced in place
   function automatic crd_pkg::rsp_type deframe(crd_pkg::req_type r);
      crd_pkg::rsp_type o;
      o.kind = crd_pkg::KIND_HEADER;
      o.buffer_index = 1'b0;
      o.buffer_offset = '0;
      o.data_out = '0;
      o.status = crd_pkg::ST_OK;
      o.error_code = '0;
      o.done_res = 1'b0;

      if (r.mode == crd_pkg::MODE_EOM) begin
         o.kind = crd_pkg::KIND_STATUS;
         o.done_res = 1'b1;
         if (ph >= crd_pkg::PH_DONE_SERVER) o.status = latched_of(ph);
         else if (ph == crd_pkg::PH_DONE_OK && r.link_ok) o.status = crd_pkg::ST_OK;
         else o.status = crd_pkg::ST_NEED_MORE;
         if (o.status == crd_pkg::ST_SERVER) o.error_code = srv_code;
         rearm_model();
         return o;
      end

      case (ph)
         crd_pkg::PH_HEADER: begin
            if (hdr_cnt == 0) begin
               srv_code = r.data_byte;
               len_acc = '0;
            end else begin
               len_acc |= 64'(r.data_byte) << (8 * (int'(hdr_cnt) - 1));
            end
            hdr_cnt++;
            if (hdr_cnt == crd_pkg::HEADER_BYTES) begin
               hdr_cnt = '0;
               chunk_left = len_acc;
               if (srv_code == 8'd0) begin
                  if (chunk_left > total_left) begin
                     ph = crd_pkg::PH_FAIL_LONG;
                     o.status = crd_pkg::ST_TOO_LONG;
                     o.done_res = 1'b1;
                  end else if (chunk_left == 0) begin
                     // empty payload chunk only completes when nothing is left
                     if (total_left == 0) begin
                        ph = crd_pkg::PH_DONE_OK;
                        o.done_res = 1'b1;
                     end
                  end else begin
                     ph = crd_pkg::PH_PAYLOAD;
                  end
               end else if (srv_code > cfg_max_code) begin
                  ph = crd_pkg::PH_FAIL_FLAG;
                  o.status = crd_pkg::ST_BAD_FLAG;
                  o.done_res = 1'b1;
               end else if (chunk_left[63:32] != 0) begin
                  ph = crd_pkg::PH_FAIL_LONG;
                  o.status = crd_pkg::ST_TOO_LONG;
                  o.done_res = 1'b1;
               end else if (chunk_left == 0) begin
                  ph = crd_pkg::PH_DONE_SERVER;
                  o.status = crd_pkg::ST_SERVER;
                  o.done_res = 1'b1;
               end else begin
                  ph = crd_pkg::PH_ERRTEXT;
               end
            end
         end
         crd_pkg::PH_PAYLOAD: begin
            o.kind = crd_pkg::KIND_PAYLOAD;
            o.buffer_index = buf_sel;
            o.buffer_offset = byte_off;
            o.data_out = r.data_byte;
            byte_off++;
            if (byte_off >= cfg_length) begin
               byte_off = '0;
               buf_sel = ~buf_sel;
            end
            chunk_left--;
            total_left--;
            if (total_left == 0) begin
               ph = crd_pkg::PH_DONE_OK;
               o.done_res = 1'b1;
            end else if (chunk_left == 0) begin
               ph = crd_pkg::PH_HEADER;
            end
         end
         crd_pkg::PH_ERRTEXT: begin
            o.kind = crd_pkg::KIND_TEXT;
            o.data_out = r.data_byte;
            chunk_left--;
            if (chunk_left == 0) begin
               ph = crd_pkg::PH_DONE_SERVER;
               o.status = crd_pkg::ST_SERVER;
               o.done_res = 1'b1;
            end
         end
         crd_pkg::PH_DONE_OK, crd_pkg::PH_DONE_SERVER: begin
            // a byte past the end latches a failure
            o.kind = crd_pkg::KIND_STATUS;
            ph = crd_pkg::PH_FAIL_AFTER;
            o.status = crd_pkg::ST_AFTER_END;
            o.done_res = 1'b1;
         end
         default: begin
            o.kind = crd_pkg::KIND_STATUS;
            o.status = latched_of(ph);
            o.done_res = 1'b1;
         end
      endcase
      if (o.status == crd_pkg::ST_SERVER) o.error_code = srv_code;
      return o;
   endfunction

   function automatic void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
         $error("%s: expected %0h, got %0h", name, e, a);
         errors++;
      end
   endfunction

   // result checker, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_payload;
         results_seen++;
         if (got.kind !== 2'bx) kind_hits[got.kind]++;
         if (deframed_q.size() == 0) begin
            $error("result transaction with nothing predicted: %p", got);
            errors++;
         end else begin
            want = deframed_q.pop_front();
            cmp_field("kind", 32'(want.kind), 32'(got.kind));
            cmp_field("buffer_index", 32'(want.buffer_index), 32'(got.buffer_index));
            cmp_field("buffer_offset", want.buffer_offset, got.buffer_offset);
            cmp_field("data_out", 32'(want.data_out), 32'(got.data_out));
            cmp_field("status", 32'(want.status), 32'(got.status));
            cmp_field("error_code", 32'(want.error_code), 32'(got.error_code));
            cmp_field("done_res", 32'(want.done_res), 32'(got.done_res));
         end
      end
   end

   // receiver: its own stall pattern, plus long hold-offs on request
   always @(negedge clock) begin
      recv_cycle++;
      if (hold_request) begin
         hold_left = hold_len;
         hold_request = 0;
      end
      if (recv_cycle % 300 == 0) stall_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ((recv_cycle % 5) < 2);
            default: rsp_stall <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // one request transaction; called and returns at a falling edge
   task automatic send_req(crd_pkg::req_type r);
      if (!gaps_off && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      deframed_q.insert(deframed_q.size(), deframe(r));
      sent_count++;
      if (burst_left > 0) burst_left--;
      @(negedge clock);
   endtask

   task automatic send_byte(logic [7:0] b);
      crd_pkg::req_type r;
      r.mode = crd_pkg::MODE_DATA;
      r.data_byte = b;
      r.link_ok = 1'($urandom_range(0, 1));
      send_req(r);
   endtask

   task automatic send_eom(logic ok);
      crd_pkg::req_type r;
      r.mode = crd_pkg::MODE_EOM;
      r.data_byte = 8'($urandom);
      r.link_ok = ok;
      send_req(r);
   endtask

   // flag byte, then the length little-endian
   task automatic send_header(logic [7:0] flag, logic [63:0] len);
      send_byte(flag);
      for (int i = 0; i < 8; i++) send_byte(len[8*i +: 8]);
   endtask

   task automatic send_payload(int n);
      repeat (n) send_byte(8'($urandom));
   endtask

   // sender pauses until every predicted result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // writes only with the block idle; every write re-arms a response
   task automatic write_csr(crd_pkg::csr_index_type idx, logic [31:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         crd_pkg::CSR_BUFFER_COUNT:   cfg_count = value[1:0];
         crd_pkg::CSR_BUFFER_LENGTH:  cfg_length = value;
         crd_pkg::CSR_MAX_ERROR_CODE: cfg_max_code = value[7:0];
         default: ;
      endcase
      rearm_model();
      csr_writes++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // reset settings: one buffer of one byte
   task automatic test_defaults();
      send_eom(1'b1);              // nothing arrived yet
      send_header(8'h00, 64'd1);
      send_byte(8'h00);            // completes
      send_byte(8'hFF);            // byte after end
      send_byte(8'hA5);            // ignored after failure
      send_eom(1'b1);
      send_header(8'h00, 64'd1);
      send_byte(8'hFF);
      send_eom(1'b1);
   endtask

   // two buffers of two bytes, crossing the buffer boundary mid chunk
   task automatic test_buffer_walk();
      write_csr(crd_pkg::CSR_BUFFER_COUNT, 32'd2);
      write_csr(crd_pkg::CSR_BUFFER_LENGTH, 32'd2);
      send_header(8'h00, 64'd0);   // empty payload chunk
      send_header(8'h00, 64'd3);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_header(8'h00, 64'd1);
      send_byte(8'hAA);
      send_eom(1'b0);              // complete but link failed
   endtask

   task automatic test_error_chunks();
      write_csr(crd_pkg::CSR_MAX_ERROR_CODE, 32'd1);
      send_header(8'h01, 64'd2);
      send_byte(8'h41);
      send_byte(8'h42);
      send_eom(1'b1);
      send_header(8'h02, 64'd5);   // flag above the highest code
      send_byte(8'h33);
      send_eom(1'b1);
      send_header(8'h01, 64'd0);   // empty error chunk
      send_eom(1'b0);
      write_csr(crd_pkg::CSR_MAX_ERROR_CODE, 32'd255);
      send_header(8'hFF, 64'd1);
      send_byte(8'h7E);
      send_eom(1'b1);
   endtask

   task automatic test_oversize();
      send_header(8'h00, 64'd5);   // one more than the four expected
      send_byte(8'h10);
      send_eom(1'b1);
      send_header(8'h01, 64'h1_0000_0000);
      send_eom(1'b1);
      send_header(8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
      send_eom(1'b1);
      // largest buffers: a chunk of exactly the total is legal
      write_csr(crd_pkg::CSR_BUFFER_LENGTH, 32'hFFFF_FFFF);
      send_header(8'h00, 64'h1_FFFF_FFFE);
      send_payload(3);
      send_eom(1'b1);
      send_header(8'h00, 64'h1_FFFF_FFFF);
      send_eom(1'b1);
      write_csr(crd_pkg::CSR_BUFFER_COUNT, 32'd1);
      send_header(8'h00, 64'h0_FFFF_FFFF);
      send_payload(2);
      send_eom(1'b0);
   endtask

   // receiver holds off while the sender keeps going, so the input stalls
   task automatic test_backpressure();
      write_csr(crd_pkg::CSR_BUFFER_COUNT, 32'd2);
      write_csr(crd_pkg::CSR_BUFFER_LENGTH, 32'd10);
      hold_len = 120;
      hold_request = 1;
      gaps_off = 1;
      send_header(8'h00, 64'd20);
      send_payload(20);
      send_payload(4);
      send_eom(1'b1);
      gaps_off = 0;
      drain();
   endtask

   task automatic test_random_responses(int count);
      int               stop_at;
      int               pick;
      int               n;
      int               left;
      int               k;
      int               sel;
      logic [63:0]      tot;
      logic [31:0]      len;
      logic [7:0]       flag;
      bit               need_rearm;
      crd_pkg::req_type r;
      stop_at = sent_count + count;
      need_rearm = 0;
      while (sent_count < stop_at) begin
         // new settings now and then, always after an abandoned response
         if (need_rearm || $urandom_range(0, 3) == 0) begin
            sel = $urandom_range(1, 7);
            if (sel[0]) write_csr(crd_pkg::CSR_BUFFER_COUNT, $urandom_range(1, 2));
            if (sel[1]) begin
               case ($urandom_range(0, 19))
                  0:       len = 32'hFFFF_FFFF;
                  1:       len = $urandom | 32'd1;
                  default: len = $urandom_range(1, 6);
               endcase
               write_csr(crd_pkg::CSR_BUFFER_LENGTH, len);
            end
            if (sel[2]) begin
               case ($urandom_range(0, 9))
                  0:       len = 32'd1;
                  1:       len = 32'd255;
                  default: len = $urandom_range(1, 255);
               endcase
               write_csr(crd_pkg::CSR_MAX_ERROR_CODE, len);
            end
            need_rearm = 0;
         end
         tot = response_bytes();
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            // well-formed response split into random chunks
            if (tot > 40) begin
               send_header(8'h00, tot);
               send_payload($urandom_range(1, 6));
            end else begin
               left = int'(tot);
               while (left > 0) begin
                  if ($urandom_range(0, 5) == 0) send_header(8'h00, 64'd0);
                  n = $urandom_range(1, left);
                  send_header(8'h00, 64'(n));
                  send_payload(n);
                  left -= n;
               end
               if ($urandom_range(0, 4) == 0) send_payload($urandom_range(1, 3));
            end
            send_eom($urandom_range(0, 7) != 0);
         end else if (pick < 65) begin
            // server error, possibly after part of the payload
            k = (tot > 40) ? $urandom_range(0, 5) : $urandom_range(0, int'(tot) - 1);
            if (k > 0) begin
               send_header(8'h00, 64'(k));
               send_payload(k);
            end
            n = $urandom_range(0, 5);
            send_header(8'($urandom_range(1, cfg_max_code)), 64'(n));
            send_payload(n);
            if ($urandom_range(0, 3) == 0) send_payload($urandom_range(1, 2));
            send_eom(1'($urandom_range(0, 1)));
         end else if (pick < 75) begin
            // chunk lengths at and past the limits
            case ($urandom_range(0, 3))
               0: send_header(8'h00, tot + 64'($urandom_range(1, 3)));
               1: send_header(8'h00, {1'b1, 31'($urandom), 32'($urandom)});
               2: send_header(8'($urandom_range(1, cfg_max_code)),
                              (64'd1 << $urandom_range(32, 63)) | 64'($urandom));
               default: send_header(8'($urandom_range(1, cfg_max_code)), 64'hFFFF_FFFF);
            endcase
            send_payload($urandom_range(0, 2));
            send_eom(1'($urandom_range(0, 1)));
         end else if (pick < 83) begin
            flag = (cfg_max_code == 8'hFF) ? 8'hFF
                                           : 8'($urandom_range(int'(cfg_max_code) + 1, 255));
            send_header(flag, {32'($urandom), 32'($urandom)});
            send_payload($urandom_range(0, 2));
            send_eom(1'($urandom_range(0, 1)));
         end else if (pick < 92) begin
            // noise, with the odd end of message mixed in
            repeat ($urandom_range(1, 15)) begin
               r.mode = ($urandom_range(0, 7) == 0) ? crd_pkg::MODE_EOM : crd_pkg::MODE_DATA;
               r.data_byte = 8'($urandom);
               r.link_ok = 1'($urandom_range(0, 1));
               send_req(r);
            end
            send_eom(1'b1);
         end else begin
            // cut short in the header or in the payload
            if ($urandom_range(0, 1)) begin
               send_payload($urandom_range(1, 8));
            end else begin
               send_header(8'h00, tot);
               send_payload((tot > 40) ? $urandom_range(0, 5)
                                       : $urandom_range(0, int'(tot) - 1));
            end
            if ($urandom_range(0, 1)) send_eom(1'($urandom_range(0, 1)));
            else need_rearm = 1;
         end
      end
   endtask

   initial begin
      rearm_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_defaults();
      test_buffer_walk();
      test_error_chunks();
      test_oversize();
      test_backpressure();
      test_random_responses(750);

      drain();
      // a few more cycles so a stray result would still be caught
      repeat (8) @(posedge clock);

      $display("sent %0d request transactions over %0d register writes, checked %0d results",
               sent_count, csr_writes, results_seen);
      $display("results by kind: header %0d, payload %0d, error text %0d, status %0d",
               kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
      if (errors == 0) begin
         $display("** chunked_response_deframer_core: PASSED **");
      end else begin
         $display("** chunked_response_deframer_core: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("** chunked_response_deframer_core: FAILED **");
      $finish;
   end

endmodule
